>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> hw/rtl/vffp_pkg.sv
`default_nettype none

package vffp_pkg;

  localparam int NumValves = 8;
  localparam int FrameLen  = NumValves + 1;
  localparam int LineLimit = 80;
  localparam int LineW     = $clog2(LineLimit + 1);
  localparam int CntW      = $clog2(FrameLen + 1);
  localparam int ValveW    = 8;
  localparam int ByteW     = 8;

  localparam logic [ByteW-1:0] CharOpen  = 8'h7B;
  localparam logic [ByteW-1:0] CharClose = 8'h7D;
  localparam logic [ByteW-1:0] CharNl    = 8'h0A;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharOne   = 8'h31;

  typedef enum logic {
    ReqByte  = 1'b0,
    ReqClear = 1'b1
  } req_type_e;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic              frame_accepted;
    logic              pump_bit;
    logic [ValveW-1:0] valve_bits;
    logic              have_feedback;
    logic              changed;
  } res_beat_t;

  // what the line tracker reports for the byte at hand
  typedef struct packed {
    logic                ok;
    logic [FrameLen-1:0] bits;
  } line_res_t;

  // low valve bits of a stored frame, zero padded when there are few valves
  function automatic logic [ValveW-1:0] valves_of(input logic [FrameLen-1:0] fb);
    logic [FrameLen+ValveW-1:0] ext;
    ext = {{ValveW{1'b0}}, fb};
    return ext[ValveW:1];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vffp_stream_if.sv
`default_nettype none

interface vffp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface vffp_res_if;
  logic       valid;
  logic       ready;
  logic       frame_accepted;
  logic       pump_bit;
  logic [7:0] valve_bits;
  logic       have_feedback;
  logic       changed;

  modport source (output valid, output frame_accepted, output pump_bit, output valve_bits,
                  output have_feedback, output changed, input ready);
  modport sink (input valid, input frame_accepted, input pump_bit, input valve_bits,
                input have_feedback, input changed, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vffp_line.sv
`default_nettype none
`include "assert_macros.svh"

module vffp_line (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic [vffp_pkg::ByteW-1:0] byte_i,
  output vffp_pkg::line_res_t           res_o
);

  logic [vffp_pkg::LineW-1:0]    len_q, len_d;
  logic                          open_q, open_d;
  logic                          close_q, close_d;
  logic                          bad_q, bad_d;
  logic [vffp_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [vffp_pkg::FrameLen-1:0] bits_q, bits_d;
  logic                          is_nl;

  assign is_nl = (byte_i == vffp_pkg::CharNl);

  assign res_o.ok = is_nl && open_q && close_q && !bad_q &&
                    (cnt_q == vffp_pkg::CntW'(vffp_pkg::FrameLen));
  assign res_o.bits = bits_q;

  always_comb begin
    len_d   = len_q;
    open_d  = open_q;
    close_d = close_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    if (step_i) begin
      if (is_nl || len_q >= vffp_pkg::LineW'(vffp_pkg::LineLimit)) begin
        // end of line, or over-long line: drop everything held
        len_d   = '0;
        open_d  = 1'b0;
        close_d = 1'b0;
        bad_d   = 1'b0;
        cnt_d   = '0;
        bits_d  = '0;
      end else begin
        len_d = len_q + vffp_pkg::LineW'(1);
        if (!open_q) begin
          if (byte_i == vffp_pkg::CharOpen) begin
            open_d = 1'b1;
          end else if (byte_i == vffp_pkg::CharClose) begin
            bad_d = 1'b1;
          end
        end else if (!close_q) begin
          if (byte_i == vffp_pkg::CharClose) begin
            close_d = 1'b1;
          end else if (cnt_q < vffp_pkg::CntW'(vffp_pkg::FrameLen)) begin
            if (byte_i == vffp_pkg::CharOne) begin
              bits_d = bits_q | (vffp_pkg::FrameLen'(1) << cnt_q);
            end else if (byte_i != vffp_pkg::CharZero) begin
              bad_d = 1'b1;
            end
            cnt_d = cnt_q + vffp_pkg::CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      open_q  <= 1'b0;
      close_q <= 1'b0;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
      bits_q  <= '0;
    end else begin
      len_q   <= len_d;
      open_q  <= open_d;
      close_q <= close_d;
      bad_q   <= bad_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
    end
  end

  `ASSERT_NEVER(a_len_limit, clk_i, rst_ni, len_q > vffp_pkg::LineW'(vffp_pkg::LineLimit))
  `ASSERT_CLK(a_close_after_open, clk_i, rst_ni, close_q |-> open_q)
  `ASSERT_CLK(a_cnt_needs_open, clk_i, rst_ni, (cnt_q != '0) |-> (open_q && len_q != '0))

endmodule

`default_nettype wire

>>> hw/rtl/valve_feedback_frame_parser.sv
// an accepted beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while the receiver takes results, input register and result register in line
// the input side keeps taking beats while a result waits, until both stages are full
// reset clears the line state, stored feedback, have-feedback and changed flags
`default_nettype none
`include "assert_macros.svh"

module valve_feedback_frame_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vffp_req_if.sink   req_i,
  vffp_res_if.source res_o
);

  logic                          s1_valid_q;
  vffp_pkg::in_beat_t            s1_beat_q;
  logic                          out_valid_q;
  vffp_pkg::res_beat_t           out_q, out_d;
  logic [vffp_pkg::FrameLen-1:0] fb_q, fb_d;
  logic                          have_q, have_d;
  logic                          changed_q, changed_d;
  logic                          adv, proc, is_clear, step, upd;
  vffp_pkg::line_res_t           line_res;

  assign adv         = !out_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || adv;
  assign proc        = s1_valid_q && adv;
  assign is_clear    = (s1_beat_q.req_type == vffp_pkg::ReqClear);
  assign step        = proc && !is_clear;
  assign upd         = step && line_res.ok;

  vffp_line u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_beat_q.rx_byte),
    .res_o  (line_res)
  );

  always_comb begin
    fb_d      = fb_q;
    have_d    = have_q;
    changed_d = changed_q;
    if (proc && is_clear) begin
      changed_d = 1'b0;
    end else if (upd) begin
      if (!have_q || line_res.bits != fb_q) begin
        changed_d = 1'b1;
      end
      fb_d   = line_res.bits;
      have_d = 1'b1;
    end
    out_d.frame_accepted = upd;
    out_d.pump_bit       = fb_d[0];
    out_d.valve_bits     = vffp_pkg::valves_of(fb_d);
    out_d.have_feedback  = have_d;
    out_d.changed        = changed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fb_q        <= '0;
      have_q      <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      fb_q      <= fb_d;
      have_q    <= have_d;
      changed_q <= changed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_beat_q.req_type <= req_i.req_type;
      s1_beat_q.rx_byte  <= req_i.rx_byte;
    end
    if (proc) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.frame_accepted = out_q.frame_accepted;
  assign res_o.pump_bit       = out_q.pump_bit;
  assign res_o.valve_bits     = out_q.valve_bits;
  assign res_o.have_feedback  = out_q.have_feedback;
  assign res_o.changed        = out_q.changed;

  `ASSERT_CLK(a_accept_has_fb, clk_i, rst_ni, (out_valid_q && out_q.frame_accepted) |-> out_q.have_feedback)
  `ASSERT_CLK(a_have_sticky, clk_i, rst_ni, have_q |=> have_q)
  `ASSERT_CLK(a_first_frame_changed, clk_i, rst_ni, $rose(have_q) |-> changed_q)
  `ASSERT_CLK(a_no_proc_hold, clk_i, rst_ni, !proc |=> ($stable(fb_q) && $stable(changed_q)))

endmodule

`default_nettype wire

>>> tb/sv/vffp_checker.sv
`default_nettype none

module vffp_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vffp_req_if         req_i,
  vffp_res_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  import vffp_pkg::*;

  // line tracker copy
  logic [LineW-1:0]    line_len;
  logic                seen_open;
  logic                seen_close;
  logic                line_bad;
  logic [CntW-1:0]     content_cnt;
  logic [FrameLen-1:0] frame_bits;
  // stored feedback copy
  logic [FrameLen-1:0] stored_bits;
  logic                have_fb;
  logic                changed_flag;

  res_beat_t   status_q[$];
  in_beat_t    beat;
  res_beat_t   want;
  res_beat_t   got;
  int unsigned mismatch_cnt = 0;

  task automatic clear_line();
    line_len    = '0;
    seen_open   = 1'b0;
    seen_close  = 1'b0;
    line_bad    = 1'b0;
    content_cnt = '0;
    frame_bits  = '0;
  endtask

  task automatic take_char(input logic [ByteW-1:0] c);
    if (!seen_open) begin
      if (c == CharOpen) seen_open = 1'b1;
      else if (c == CharClose) line_bad = 1'b1;
    end else if (!seen_close) begin
      if (c == CharClose) begin
        seen_close = 1'b1;
      end else if (content_cnt < FrameLen) begin
        if (c == CharOne) frame_bits[content_cnt] = 1'b1;
        else if (c != CharZero) line_bad = 1'b1;
        content_cnt++;
      end
    end
  endtask

  task automatic parse_beat(input in_beat_t b, output res_beat_t r);
    logic ok;
    ok = 1'b0;
    if (b.req_type == ReqClear) begin
      changed_flag = 1'b0;
    end else if (b.rx_byte == CharNl) begin
      ok = seen_open && seen_close && !line_bad && (content_cnt >= FrameLen);
      if (ok) begin
        if (!have_fb || frame_bits != stored_bits) changed_flag = 1'b1;
        stored_bits = frame_bits;
        have_fb     = 1'b1;
      end
      clear_line();
    end else if (line_len < LineLimit) begin
      line_len++;
      take_char(b.rx_byte);
    end else begin
      // over-long line, byte is dropped
      clear_line();
    end
    r.frame_accepted = ok;
    r.pump_bit       = stored_bits[0];
    r.valve_bits     = stored_bits[ValveW:1];
    r.have_feedback  = have_fb;
    r.changed        = changed_flag;
  endtask

  task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      stored_bits  = '0;
      have_fb      = 1'b0;
      changed_flag = 1'b0;
      status_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.frame_accepted = res_i.frame_accepted;
        got.pump_bit       = res_i.pump_bit;
        got.valve_bits     = res_i.valve_bits;
        got.have_feedback  = res_i.have_feedback;
        got.changed        = res_i.changed;
        if (status_q.size() == 0) begin
          $error("result beat with no status pending");
          mismatch_cnt++;
        end else begin
          want = status_q.pop_front();
          cmp_field("frame_accepted", want.frame_accepted, got.frame_accepted);
          cmp_field("pump_bit", want.pump_bit, got.pump_bit);
          cmp_field("valve_bits", want.valve_bits, got.valve_bits);
          cmp_field("have_feedback", want.have_feedback, got.have_feedback);
          cmp_field("changed", want.changed, got.changed);
        end
      end
      if (req_i.valid && req_i.ready) begin
        beat.req_type = req_i.req_type;
        beat.rx_byte  = req_i.rx_byte;
        parse_beat(beat, want);
        status_q.push_back(want);
      end
    end
    pending_o      <= 32'(status_q.size());
    mismatch_cnt_o <= mismatch_cnt;
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_valve_feedback_frame_parser.sv
`default_nettype none

module tb_valve_feedback_frame_parser;
  import vffp_pkg::*;

  localparam int unsigned BeatTarget = 930;
  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [1:0] {
    RxFlow,
    RxCoin,
    RxStall
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  vffp_req_if req_if ();
  vffp_res_if res_if ();

  valve_feedback_frame_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  vffp_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure
  rx_mode_e    rx_mode = RxFlow;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  logic        rx_level = 1'b1;
  always @(posedge clk_i) begin
    if (rx_cycle % 200 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
    rx_cycle++;
    case (rx_mode)
      RxFlow: begin
        res_if.ready <= 1'b1;
      end
      RxCoin: begin
        res_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left == 0) begin
          rx_level  = !rx_level;
          hold_left = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        hold_left--;
        res_if.ready <= rx_level;
      end
    endcase
  end

  // sender
  int unsigned      burst_left = 0;
  int unsigned      beats_sent = 0;
  bit               steady = 1'b0;
  logic [ByteW-1:0] line_q[$];

  task automatic send_beat(input req_type_e rq, input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rq;
    req_if.rx_byte  <= b;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    beats_sent++;
  endtask

  // clear_odds of zero sends the line untouched, else one clear in clear_odds per byte
  task automatic send_line(input int unsigned clear_odds);
    foreach (line_q[i]) begin
      if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1)
        send_beat(ReqClear, 8'($urandom_range(0, 255)));
      send_beat(ReqByte, line_q[i]);
    end
    line_q.delete();
  endtask

  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharOpen || b == CharClose || b == CharNl);
    return b;
  endfunction

  task automatic push_frame(input logic [FrameLen-1:0] bits, input int unsigned extra_n);
    line_q.push_back(CharOpen);
    for (int i = 0; i < FrameLen; i++) line_q.push_back(bits[i] ? CharOne : CharZero);
    repeat (extra_n) line_q.push_back(plain_byte());
    line_q.push_back(CharClose);
  endtask

  initial begin
    int unsigned         kind;
    int unsigned         open_idx;
    int unsigned         n;
    logic [FrameLen-1:0] bits;
    logic [FrameLen-1:0] last_bits;
    logic [ByteW-1:0]    b;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = ReqByte;
    req_if.rx_byte  = '0;
    res_if.ready    = 1'b0;
    last_bits       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame, then a clear
    push_frame(9'h155, 0);
    line_q.push_back(CharNl);
    send_line(0);
    send_beat(ReqClear, 8'hFF);
    // zero and all-ones bytes, close before open
    line_q = '{8'h00, 8'hFF, CharClose, CharNl};
    send_line(0);
    // all ones, differs from the stored bits
    push_frame(9'h1FF, 0);
    line_q.push_back(CharNl);
    send_line(0);

    while (beats_sent < BeatTarget) begin
      if ($urandom_range(0, 99) == 0) steady = !steady;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // frames, some of them broken
        bits = ($urandom_range(0, 1) == 0) ? last_bits : FrameLen'($urandom);
        repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
        open_idx = line_q.size();
        push_frame(bits, (kind < 65) ? $urandom_range(0, 3) : 0);
        if (kind >= 65) begin
          case ($urandom_range(0, 4))
            0: begin
              do b = plain_byte(); while (b == CharZero || b == CharOne);
              line_q[open_idx + 1 + $urandom_range(0, FrameLen - 1)] = b;
            end
            1: begin
              n = $urandom_range(1, FrameLen);
              repeat (n) line_q.delete(open_idx + 1);
            end
            2: line_q.delete(line_q.size() - 1);
            3: line_q.delete(open_idx);
            default: line_q.insert(open_idx, CharClose);
          endcase
        end else begin
          last_bits = bits;
        end
        repeat ($urandom_range(0, 3)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CharNl);
          line_q.push_back(b);
        end
        line_q.push_back(CharNl);
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 96) begin
        // runs up to or past the line limit, sometimes with a frame right after
        repeat ($urandom_range(LineLimit - 2, LineLimit + 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CharNl);
          line_q.push_back(b);
        end
        if ($urandom_range(0, 1) == 1) push_frame(FrameLen'($urandom), 0);
        line_q.push_back(CharNl);
      end else begin
        repeat ($urandom_range(1, 3)) send_beat(ReqClear, 8'($urandom_range(0, 255)));
      end
      send_line(20);
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
